/* design/itf_pkg.sv */
`timescale 1ns / 1ps

package itf_pkg;

  localparam int VALUE_BITS_DEF    = 64;
  localparam int MAX_WIDTH_DEF     = 64;
  localparam int MAX_PRECISION_DEF = 60;

  localparam int CHAR_W  = 8;
  localparam int CNT_W   = 8;
  localparam int FW_W    = 7;
  localparam int PREC_W  = 6;
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 64;

  localparam logic [KIND_W-1:0] KIND_SDEC  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UDEC  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OCT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HEXLO = 3'd3;
  localparam logic [KIND_W-1:0] KIND_HEXUP = 3'd4;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_NORM = 5'b00100,
    S_PLAN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    SEG_LEAD  = 3'd0,
    SEG_SIGN  = 3'd1,
    SEG_PRE0  = 3'd2,
    SEG_PRE1  = 3'd3,
    SEG_ZEROS = 3'd4,
    SEG_DIGS  = 3'd5,
    SEG_TRAIL = 3'd6
  } seg_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (d < 4'd10) digit_char = CH_ZERO + {4'd0, d};
    else           digit_char = base + {4'd0, d} - 8'd10;
  endfunction

endpackage

/* design/integer_to_text_formatter.sv */
`timescale 1ns / 1ps
// printf-style integer conversion, one conversion per input transaction
// input channel: in_valid/in_ready carry kind, value, flags, width, precision;
// in_ready is high only while the block is idle, one conversion at a time
// output channel: out_valid/out_ready carry one ASCII character per transaction,
// out_last marks the final character; an empty conversion gives one transaction
// with out_has_char 0
// flow: decimal kinds run a shift-and-add-3 binary to BCD converter, one value
// bit per cycle; octal and hex load all their digits at once; a digit-serial
// normalize then drops leading zero digits, one per cycle, and the planning
// state then sizes the field
// characters leave at one per cycle while out_ready is high, with a pause at
// each change of field segment (at most 6)
// the output register holds its character while out_ready is low and the
// sequencer waits; nothing is lost or repeated
// reset (rst_n low, synchronous) returns to idle and drops out_valid
module integer_to_text_formatter
  import itf_pkg::*;
#(
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_PRECISION = MAX_PRECISION_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic                in_flag_minus,
  input  logic                in_flag_plus,
  input  logic                in_flag_space,
  input  logic                in_flag_zero,
  input  logic                in_flag_alt,
  input  logic [FW_W-1:0]     in_field_width,
  input  logic                in_has_precision,
  input  logic [PREC_W-1:0]   in_precision,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   out_character,
  output logic                out_has_char,
  output logic                out_last
);

  localparam int DIG   = (VALUE_BITS + 2) / 3;
  localparam int DW    = 4 * DIG;
  localparam int BC_W  = $clog2(VALUE_BITS + 1);
  localparam int ND_W  = $clog2(DIG + 1);

  state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] mag_r, sh_r;
  logic                  dec_r, oct_r, hex_r, upper_r;
  logic                  sign_on_r;
  logic [CHAR_W-1:0]     sign_char_r;
  logic                  minus_r, zero_r, alt_r, has_prec_r;
  logic [FW_W-1:0]       width_r;
  logic [PREC_W-1:0]     prec_r;
  logic [DW-1:0]         dig_r;
  logic [BC_W-1:0]       bit_cnt_r;
  logic [ND_W-1:0]       nd_cnt_r;
  logic [CNT_W-1:0]      nd_r, zeros_r, spaces_r, total_r, cnt_r;
  logic [1:0]            pl_r;
  seg_t                  seg_r;

  logic                  out_valid_r, out_has_char_r, out_last_r;
  logic [CHAR_W-1:0]     out_character_r;

  // input decode
  logic [KIND_W-1:0]     k_in;
  logic [VALUE_BITS-1:0] v_in;
  logic                  neg_in;
  always_comb begin
    k_in   = (in_kind > KIND_HEXUP) ? KIND_UDEC : in_kind;
    v_in   = in_value[VALUE_BITS-1:0];
    neg_in = (k_in == KIND_SDEC) && v_in[VALUE_BITS-1];
  end

  // shift and add 3 step
  logic [DW-1:0] dd_adj, dd_nxt;
  always_comb begin
    for (int i = 0; i < DIG; i++) begin
      dd_adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3
                                                   : dig_r[4*i +: 4];
    end
    dd_nxt = {dd_adj[DW-2:0], sh_r[VALUE_BITS-1]};
  end

  // direct digit load for octal and hex
  logic [3*DIG-1:0] ext3;
  logic [DW-1:0]    ext4, oct_dig;
  always_comb begin
    ext3 = (3*DIG)'(mag_r);
    ext4 = DW'(mag_r);
    for (int i = 0; i < DIG; i++) begin
      oct_dig[4*i +: 4] = {1'b0, ext3[3*i +: 3]};
    end
  end

  // field plan
  logic             mag_zero, suppress;
  logic [CNT_W-1:0] p_nd, p_zeros0, p_zeros, p_body0, p_body, p_spaces, p_wd;
  logic [1:0]       p_pl;
  always_comb begin
    mag_zero = (mag_r == '0);
    suppress = mag_zero && has_prec_r && (prec_r == '0);
    p_nd     = suppress ? '0 : CNT_W'(nd_cnt_r);
    p_zeros0 = (has_prec_r && (CNT_W'(prec_r) > p_nd)) ? CNT_W'(prec_r) - p_nd : '0;
    if (alt_r && oct_r && (p_zeros0 == '0) && ((p_nd == '0) || !mag_zero)) p_pl = 2'd1;
    else if (alt_r && hex_r && !mag_zero)                                   p_pl = 2'd2;
    else                                                                    p_pl = 2'd0;
    p_body0 = CNT_W'(sign_on_r) + CNT_W'(p_pl) + p_zeros0 + p_nd;
    p_wd    = CNT_W'(width_r);
    if (zero_r && !has_prec_r && !minus_r && (p_wd > p_body0)) begin
      p_zeros = p_zeros0 + p_wd - p_body0;
      p_body  = p_wd;
    end else begin
      p_zeros = p_zeros0;
      p_body  = p_body0;
    end
    p_spaces = (p_wd > p_body) ? p_wd - p_body : '0;
  end

  // segment lengths
  seg_t             seg_next;
  logic [CNT_W-1:0] next_len;
  always_comb begin
    seg_next = seg_t'(seg_r + 3'd1);
    case (seg_next)
      SEG_LEAD:  next_len = minus_r ? '0 : spaces_r;
      SEG_SIGN:  next_len = CNT_W'(sign_on_r);
      SEG_PRE0:  next_len = CNT_W'(pl_r >= 2'd1);
      SEG_PRE1:  next_len = CNT_W'(pl_r >= 2'd2);
      SEG_ZEROS: next_len = zeros_r;
      SEG_DIGS:  next_len = nd_r;
      SEG_TRAIL: next_len = minus_r ? spaces_r : '0;
      default:   next_len = '0;
    endcase
  end

  logic [CHAR_W-1:0] cur_char;
  always_comb begin
    case (seg_r)
      SEG_SIGN:  cur_char = sign_char_r;
      SEG_PRE0:  cur_char = CH_ZERO;
      SEG_PRE1:  cur_char = upper_r ? CH_X_UP : CH_X_LO;
      SEG_ZEROS: cur_char = CH_ZERO;
      SEG_DIGS:  cur_char = digit_char(dig_r[DW-1 -: 4], upper_r);
      default:   cur_char = CH_SPACE;
    endcase
  end

  logic can_out;
  assign can_out = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CONV;
      S_CONV: if (!dec_r || (bit_cnt_r == BC_W'(VALUE_BITS - 1))) state_nxt = S_NORM;
      S_NORM: if ((nd_cnt_r <= ND_W'(1)) || (dig_r[DW-1 -: 4] != 4'd0)) state_nxt = S_PLAN;
      S_PLAN: state_nxt = S_EMIT;
      S_EMIT: begin
        if (can_out && ((total_r == '0) || ((cnt_r != '0) && (total_r == CNT_W'(1)))))
          state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_EMIT) && can_out && ((total_r == '0) || (cnt_r != '0)))
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        mag_r       <= neg_in ? (~v_in + 1'b1) : v_in;
        sh_r        <= neg_in ? (~v_in + 1'b1) : v_in;
        dec_r       <= (k_in == KIND_SDEC) || (k_in == KIND_UDEC);
        oct_r       <= (k_in == KIND_OCT);
        hex_r       <= (k_in == KIND_HEXLO) || (k_in == KIND_HEXUP);
        upper_r     <= (k_in != KIND_HEXLO);
        sign_on_r   <= (k_in == KIND_SDEC) && (neg_in || in_flag_plus || in_flag_space);
        sign_char_r <= neg_in ? CH_MINUS : (in_flag_plus ? CH_PLUS : CH_SPACE);
        minus_r     <= in_flag_minus;
        zero_r      <= in_flag_zero;
        alt_r       <= in_flag_alt;
        has_prec_r  <= in_has_precision;
        width_r     <= (in_field_width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH)
                                                            : in_field_width;
        prec_r      <= (in_precision > PREC_W'(MAX_PRECISION)) ? PREC_W'(MAX_PRECISION)
                                                                : in_precision;
        dig_r       <= '0;
        bit_cnt_r   <= '0;
        nd_cnt_r    <= ND_W'(DIG);
      end
      S_CONV: begin
        if (dec_r) begin
          dig_r     <= dd_nxt;
          sh_r      <= {sh_r[VALUE_BITS-2:0], 1'b0};
          bit_cnt_r <= bit_cnt_r + 1'b1;
        end else begin
          dig_r <= oct_r ? oct_dig : ext4;
        end
      end
      S_NORM: begin
        if ((nd_cnt_r > ND_W'(1)) && (dig_r[DW-1 -: 4] == 4'd0)) begin
          dig_r    <= {dig_r[DW-5:0], 4'd0};
          nd_cnt_r <= nd_cnt_r - 1'b1;
        end
      end
      S_PLAN: begin
        nd_r     <= p_nd;
        zeros_r  <= p_zeros;
        spaces_r <= p_spaces;
        pl_r     <= p_pl;
        total_r  <= p_body + p_spaces;
        seg_r    <= SEG_LEAD;
        cnt_r    <= minus_r ? '0 : p_spaces;
      end
      S_EMIT: begin
        if (total_r == '0) begin
          if (can_out) begin
            out_character_r <= '0;
            out_has_char_r  <= 1'b0;
            out_last_r      <= 1'b1;
          end
        end else if (cnt_r == '0) begin
          seg_r <= seg_next;
          cnt_r <= next_len;
        end else if (can_out) begin
          out_character_r <= cur_char;
          out_has_char_r  <= 1'b1;
          out_last_r      <= (total_r == CNT_W'(1));
          cnt_r           <= cnt_r - 1'b1;
          total_r         <= total_r - 1'b1;
          if (seg_r == SEG_DIGS) dig_r <= {dig_r[DW-5:0], 4'd0};
        end
      end
      default: ;
    endcase
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_has_char  = out_has_char_r;
  assign out_last      = out_last_r;

endmodule
